// ===== rtl/scpa_pkg.sv =====
// Shared types and constants of the size class pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

  localparam int ADDR_W  = 20;
  localparam int SIZE_W  = 32;
  localparam int GRAIN_SHIFT = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_LARGE     = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_HEAD,
    S_POP,
    S_CARVE,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/scpa_if.sv =====
// Request and response channel interfaces of the size class pool allocator.
`timescale 1ns / 1ps
`default_nettype none

interface scpa_req_if;
  import scpa_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [SIZE_W-1:0]   request_bytes;
  logic [ADDR_W-1:0]   release_address;

  modport source (output valid, output mode, output request_bytes,
                  output release_address, input ready);
  modport sink   (input valid, input mode, input request_bytes,
                  input release_address, output ready);
endinterface

interface scpa_rsp_if;
  import scpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   unit_address;
  logic [1:0]          status;

  modport source (output valid, output unit_address, output status, input ready);
  modport sink   (input valid, input unit_address, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/size_class_pool_allocator.sv =====
// Small-object pool allocator with per-size-class free lists in on-chip memory.
// The req channel carries one item per request: mode (allocate or release),
// request_bytes and release_address. The rsp channel returns exactly one item
// per request: unit_address and status. Sizes map to classes of 8-byte units.
// An allocate pops its class list; if that list is empty a fresh block is
// carved into units, one link write per cycle through the shared offset adder.
// A release pushes the unit onto its class list if its address lies in the pool.
// After accept, S_LOOKUP sends a zero-size or too-large request straight to the
// output register and otherwise reads the head memory; S_HEAD finishes a
// release or an exhausted pool, S_POP finishes a pop, and S_CARVE links the
// units of a fresh block before the result is shown.
// A pop reads the head memory, then the link memory.
// One item is in flight at a time: req.ready is high only while idle.
// After reset the head memory is swept to empty, one class per cycle;
// req.ready stays low until the sweep ends.
// A result waits in the output register while rsp.ready is low, and no new
// item is accepted until it has been taken.
`timescale 1ns / 1ps
`default_nettype none

module size_class_pool_allocator #(
  parameter int NUM_SIZE_CLASSES = 128,
  parameter int MAX_SMALL_BYTES  = 1024,
  parameter int BLOCK_BYTES      = 16384,
  parameter int MAX_BLOCKS       = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  scpa_req_if.sink   req,
  scpa_rsp_if.source rsp
);
  import scpa_pkg::*;

  localparam int GPB    = BLOCK_BYTES / 8;
  localparam int POOL_G = MAX_BLOCKS * GPB;
  localparam int GW     = $clog2(POOL_G);
  localparam int CW     = (NUM_SIZE_CLASSES > 1) ? $clog2(NUM_SIZE_CLASSES) : 1;
  localparam int UGW    = CW + 1;
  localparam int OW     = $clog2(GPB + 2 * NUM_SIZE_CLASSES + 1) + 1;
  localparam int BW     = $clog2(MAX_BLOCKS + 1);
  localparam int RGW    = ADDR_W - GRAIN_SHIFT;
  localparam logic [GW:0] LINK_NULL = {1'b1, {GW{1'b0}}};

  // Head and link memories; the top bit of an entry marks an empty link.
  logic [GW:0] head_mem [NUM_SIZE_CLASSES];
  logic [GW:0] link_mem [POOL_G];

  state_t state, state_next;

  logic [CW-1:0]     clr_idx, clr_idx_next;
  logic [OW-1:0]     off, off_next;
  logic [BW-1:0]     blocks, blocks_next;
  logic [GW-1:0]     base, base_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  status_t           res_status, res_status_next;

  // Captured request.
  mode_t         mode_r;
  logic [CW-1:0] cls_r;
  logic [GW-1:0] gran_r;
  logic          in_pool_r;
  status_t       pre_status_r;

  logic [GW:0] head_q;
  logic [GW:0] link_q;

  // Request decode.
  logic [SIZE_W-1:0]             size_m1;
  logic [SIZE_W-GRAIN_SHIFT-1:0] cls_full;
  logic [RGW-1:0]                rel_gran;
  logic                          accept;
  status_t                       pre_status;

  // Carve arithmetic.
  logic [UGW-1:0] unit_gr;
  logic [OW-1:0]  ug_ext;
  logic [OW-1:0]  nxt;
  logic [OW-1:0]  nxt2;
  logic           last_unit;
  logic [GW-1:0]  cur_gran;
  logic [GW-1:0]  nxt_gran;

  // Memory controls.
  logic          hd_we;
  logic [CW-1:0] hd_wa;
  logic [GW:0]   hd_wd;
  logic          hd_re;
  logic          ln_we;
  logic [GW-1:0] ln_wa;
  logic [GW:0]   ln_wd;
  logic          ln_re;

  assign accept   = req.valid && req.ready;
  assign size_m1  = req.request_bytes - SIZE_W'(1);
  assign cls_full = size_m1[SIZE_W-1:GRAIN_SHIFT];
  assign rel_gran = req.release_address[ADDR_W-1:GRAIN_SHIFT];

  always_comb begin
    if (req.request_bytes == '0) begin
      pre_status = ST_ZERO;
    end else if (req.request_bytes > SIZE_W'(MAX_SMALL_BYTES) ||
                 32'(cls_full) >= NUM_SIZE_CLASSES) begin
      pre_status = ST_LARGE;
    end else begin
      pre_status = ST_OK;
    end
  end

  assign unit_gr   = UGW'(cls_r) + UGW'(1);
  assign ug_ext    = OW'(unit_gr);
  assign nxt       = off + ug_ext;
  assign nxt2      = nxt + ug_ext;
  assign last_unit = 32'(nxt2) > GPB;
  assign cur_gran  = GW'(32'(base) + 32'(off));
  assign nxt_gran  = GW'(32'(base) + 32'(nxt));

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = (state == S_OUT);
  assign rsp.unit_address = res_addr;
  assign rsp.status       = res_status;

  always_comb begin
    state_next      = state;
    clr_idx_next    = clr_idx;
    off_next        = off;
    blocks_next     = blocks;
    base_next       = base;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    hd_we = 1'b0;
    hd_wa = cls_r;
    hd_wd = LINK_NULL;
    hd_re = 1'b0;
    ln_we = 1'b0;
    ln_wa = cur_gran;
    ln_wd = LINK_NULL;
    ln_re = 1'b0;
    case (state)
      S_CLEAR: begin
        hd_we = 1'b1;
        hd_wa = clr_idx;
        clr_idx_next = clr_idx + CW'(1);
        if (clr_idx == CW'(NUM_SIZE_CLASSES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (pre_status_r != ST_OK) begin
          res_status_next = pre_status_r;
          res_addr_next   = '0;
          state_next      = S_OUT;
        end else begin
          hd_re      = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (mode_r == MODE_RELEASE) begin
          if (in_pool_r) begin
            ln_we = 1'b1;
            ln_wa = gran_r;
            ln_wd = head_q;
            hd_we = 1'b1;
            hd_wd = {1'b0, gran_r};
          end
          res_status_next = ST_OK;
          res_addr_next   = '0;
          state_next      = S_OUT;
        end else if (!head_q[GW]) begin
          ln_re      = 1'b1;
          state_next = S_POP;
        end else if (32'(blocks) >= MAX_BLOCKS || 32'(unit_gr) > GPB) begin
          res_status_next = ST_EXHAUSTED;
          res_addr_next   = '0;
          state_next      = S_OUT;
        end else begin
          off_next   = '0;
          state_next = S_CARVE;
        end
      end
      S_POP: begin
        hd_we = 1'b1;
        hd_wd = link_q;
        res_status_next = ST_OK;
        res_addr_next   = ADDR_W'({head_q[GW-1:0], 3'b000});
        state_next      = S_OUT;
      end
      S_CARVE: begin
        // Each cycle links one unit to the next; the last unit ends the list.
        ln_we = 1'b1;
        ln_wa = cur_gran;
        ln_wd = last_unit ? LINK_NULL : {1'b0, nxt_gran};
        if (off == '0) begin
          hd_we = 1'b1;
          hd_wd = ln_wd;
        end
        off_next = nxt;
        if (last_unit) begin
          blocks_next     = blocks + BW'(1);
          base_next       = GW'(32'(base) + GPB);
          res_status_next = ST_OK;
          res_addr_next   = ADDR_W'({base, 3'b000});
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      blocks     <= '0;
      base       <= '0;
      res_status <= ST_OK;
      res_addr   <= '0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_idx_next;
      blocks     <= blocks_next;
      base       <= base_next;
      res_status <= res_status_next;
      res_addr   <= res_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    off <= off_next;
    if (accept) begin
      mode_r       <= mode_t'(req.mode);
      cls_r        <= cls_full[CW-1:0];
      gran_r       <= GW'(rel_gran);
      in_pool_r    <= 32'(rel_gran) < POOL_G;
      pre_status_r <= pre_status;
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[hd_wa] <= hd_wd;
    end
    if (hd_re) begin
      head_q <= head_mem[cls_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ln_we) begin
      link_mem[ln_wa] <= ln_wd;
    end
    if (ln_re) begin
      link_q <= link_mem[head_q[GW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scpa_checker.sv =====
// Port-level checks of the size class pool allocator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module scpa_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [scpa_pkg::ADDR_W-1:0] rsp_unit_address,
  input wire logic [1:0]                  rsp_status
);
  import scpa_pkg::*;

  // The head memory sweep keeps the block busy right after reset.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("req.ready high in the cycle after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second item accepted while one is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !rsp_valid)
    else $error("result shown in the cycle after accept");

  a_zero_addr_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != ST_OK) |-> (rsp_unit_address == '0))
    else $error("nonzero unit address with a failing status");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_unit_address) && $stable(rsp_status)))
    else $error("stalled result changed");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_unit_address (rsp.unit_address),
  .rsp_status       (rsp.status)
);

`default_nettype wire
